[rtl/nftt_pkg.sv]
// nftt_pkg: shared widths, action/result codes, limits and the control/status
// structs used between the fault table controller and its datapath.
// No dependencies.
package nftt_pkg;

  localparam int ACT_W      = 2;
  localparam int NODE_W     = 5;
  localparam int TTL_IN_W   = 8;
  localparam int TYPE_W     = 3;
  localparam int XT_W       = 12;
  localparam int SECS_W     = 16;
  localparam int RES_W      = 3;
  localparam int TICKS_W    = 13;
  localparam int DELTA_W    = 12;
  localparam int CNT_W      = 6;
  localparam int IV_W       = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int ENTRY_W    = TYPE_W + TICKS_W;
  localparam int RAW_W      = SECS_W + 1;
  localparam int SUM_W      = TICKS_W + 1;

  localparam logic [ACT_W-1:0] ACT_INJECT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_EXTEND = 2'd2;
  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd3;

  localparam logic [RES_W-1:0] RES_INJECTED  = 3'd0;
  localparam logic [RES_W-1:0] RES_REMOVED   = 3'd1;
  localparam logic [RES_W-1:0] RES_EXPIRED   = 3'd2;
  localparam logic [RES_W-1:0] RES_EXTENDED  = 3'd3;
  localparam logic [RES_W-1:0] RES_SKIPPED   = 3'd4;
  localparam logic [RES_W-1:0] RES_INVALID   = 3'd5;
  localparam logic [RES_W-1:0] RES_TICK_DONE = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 1'b1;

  localparam logic [CNT_W-1:0]    NODE_COUNT_RST = 6'd32;
  localparam logic [IV_W-1:0]     IV_RST         = 5'd5;
  localparam logic [IV_W-1:0]     IV_MAX         = 5'd30;
  localparam logic [TTL_IN_W-1:0] TTL_MAX        = 8'd120;
  localparam logic [DELTA_W-1:0]  DELTA_MAX      = 12'd3600;
  localparam logic [TICKS_W-1:0]  TOTAL_MAX      = 13'd7200;

  localparam logic [TYPE_W-1:0] TYPE_AUTO     = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_AUTO_ALT = 3'd7;
  localparam logic [TYPE_W-1:0] TYPE_MIN      = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_MAX      = 3'd6;

  typedef struct packed {
    logic load_item;
    logic start_div;
    logic scan_init;
    logic scan_rd;
    logic scan_next;
    logic exec;
    logic update;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic need_div;
    logic div_busy;
    logic scan_hit;
    logic scan_last;
    logic slot_free;
  } stat_t;

endpackage

[rtl/node_fault_ttl_table.sv]
// Per-node fault table with tick-counted lifetimes. Items are inject, remove,
// extend and tick; one item is worked at a time. Inject, remove and extend go
// through accept, lookup and execute steps, and the result is loaded into the
// output register at the execute step; an extend of an active entry whose tick
// count is 0 also passes a divide step for the bit-serial seconds/interval
// divider. A tick, unless the node count is 0, walks the table one entry a
// cycle, with an added update step per active entry for its read-modify-write
// through the entry RAM, emitting an expired beat per entry that runs out
// (ascending node order) and a closing tick-done beat. A result waiting in the
// output register stalls the sequencer at the execute step, at every
// read-modify-write of the tick scan (expiring or not) and at tick done.
// Node count and interval may be written only while the block is idle.
// Depends on nftt_pkg, nftt_ctrl, nftt_datapath (nftt_ram, nftt_div).
module node_fault_ttl_table #(
  parameter int MAX_NODES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // item input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [nftt_pkg::ACT_W-1:0]      in_action,
  input  logic [nftt_pkg::NODE_W-1:0]     in_node_index,
  input  logic [nftt_pkg::TTL_IN_W-1:0]   in_requested_ttl,
  input  logic                            in_overwrite,
  input  logic [nftt_pkg::TYPE_W-1:0]     in_requested_type,
  input  logic [nftt_pkg::TYPE_W-1:0]     in_random_pick,
  input  logic [nftt_pkg::XT_W-1:0]       in_extend_ticks,
  input  logic [nftt_pkg::SECS_W-1:0]     in_extend_seconds,
  // config write port: 0 node count, 1 interval seconds
  input  logic                            cfg_we,
  input  logic [nftt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nftt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [nftt_pkg::RES_W-1:0]      out_event_res,
  output logic [nftt_pkg::NODE_W-1:0]     out_event_node,
  output logic [nftt_pkg::TYPE_W-1:0]     out_event_type,
  output logic [nftt_pkg::TICKS_W-1:0]    out_remaining_ticks,
  output logic [nftt_pkg::DELTA_W-1:0]    out_applied_delta,
  output logic [nftt_pkg::CNT_W-1:0]      out_live_count,
  output logic                            out_last
);
  import nftt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: owns the item handshake and issues the command strobes
  nftt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_action(in_action),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table storage, arithmetic and the output beat register
  nftt_datapath #(
    .MAX_NODES(MAX_NODES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_action          (in_action),
    .in_node_index      (in_node_index),
    .in_requested_ttl   (in_requested_ttl),
    .in_overwrite       (in_overwrite),
    .in_requested_type  (in_requested_type),
    .in_random_pick     (in_random_pick),
    .in_extend_ticks    (in_extend_ticks),
    .in_extend_seconds  (in_extend_seconds),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_event_node     (out_event_node),
    .out_event_type     (out_event_type),
    .out_remaining_ticks(out_remaining_ticks),
    .out_applied_delta  (out_applied_delta),
    .out_live_count     (out_live_count),
    .out_last           (out_last)
  );

  // one item in flight: in_ready is low in the cycle after an item is accepted
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted back to back");

  // a stalled beat stays put until the receiver takes it
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_event_res) && $stable(out_event_node) &&
       $stable(out_last)))
    else $error("stalled beat changed before acceptance");

  // active count never wraps
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_live_count <= CNT_W'(MAX_NODES)))
    else $error("active fault count out of range");

  // exec, update and done commands only issue when the output slot can take a beat
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec || cmd.update || cmd.done) |-> stat.slot_free)
    else $error("beat loaded over a pending result");

endmodule

[rtl/nftt_ram.sv]
// nftt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module nftt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/nftt_div.sv]
// nftt_div: restoring divider, one quotient bit per cycle, for the
// seconds-to-ticks conversion. Depends on nftt_pkg.
module nftt_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [nftt_pkg::SECS_W-1:0] dividend,
  input  logic [nftt_pkg::IV_W-1:0]   divisor,
  output logic                        busy,
  output logic [nftt_pkg::SECS_W-1:0] quotient,
  output logic                        rem_nz
);
  import nftt_pkg::*;

  localparam int STEP_W = $clog2(SECS_W + 1);

  logic              busy_r;
  logic [STEP_W-1:0] cnt_r;
  logic [SECS_W-1:0] quot_r;
  logic [IV_W-1:0]   rem_r;
  logic [IV_W:0]     trial;
  logic [IV_W:0]     diff;
  logic              ge;

  assign trial = {rem_r, quot_r[SECS_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= STEP_W'(SECS_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
    end else if (busy_r) begin
      quot_r <= {quot_r[SECS_W-2:0], ge};
      rem_r  <= ge ? diff[IV_W-1:0] : trial[IV_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quot_r;
  assign rem_nz   = |rem_r;

endmodule

[rtl/nftt_datapath.sv]
// nftt_datapath: config registers, item registers, active bits, entry RAM,
// divider, result decode and the output register. Depends on nftt_pkg,
// nftt_ram and nftt_div.
module nftt_datapath #(
  parameter int MAX_NODES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [nftt_pkg::ACT_W-1:0]      in_action,
  input  logic [nftt_pkg::NODE_W-1:0]     in_node_index,
  input  logic [nftt_pkg::TTL_IN_W-1:0]   in_requested_ttl,
  input  logic                            in_overwrite,
  input  logic [nftt_pkg::TYPE_W-1:0]     in_requested_type,
  input  logic [nftt_pkg::TYPE_W-1:0]     in_random_pick,
  input  logic [nftt_pkg::XT_W-1:0]       in_extend_ticks,
  input  logic [nftt_pkg::SECS_W-1:0]     in_extend_seconds,
  input  logic                            cfg_we,
  input  logic [nftt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nftt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  nftt_pkg::cmd_t                  cmd,
  output nftt_pkg::stat_t                 stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [nftt_pkg::RES_W-1:0]      out_event_res,
  output logic [nftt_pkg::NODE_W-1:0]     out_event_node,
  output logic [nftt_pkg::TYPE_W-1:0]     out_event_type,
  output logic [nftt_pkg::TICKS_W-1:0]    out_remaining_ticks,
  output logic [nftt_pkg::DELTA_W-1:0]    out_applied_delta,
  output logic [nftt_pkg::CNT_W-1:0]      out_live_count,
  output logic                            out_last
);
  import nftt_pkg::*;

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_NODES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);

  // configuration
  logic [CNT_W-1:0] node_count_r;
  logic [IV_W-1:0]  interval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
      interval_r   <= IV_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_COUNT: node_count_r <= cfg_wdata;
        CFG_INTERVAL:   interval_r   <= cfg_wdata[IV_W-1:0];
        default:        ;
      endcase
    end
  end

  logic [CNT_W-1:0] limit;
  logic [IV_W-1:0]  iv;

  assign limit = (node_count_r > MAX_CNT) ? MAX_CNT : node_count_r;
  assign iv    = (interval_r == '0) ? IV_W'(1) :
                 ((interval_r > IV_MAX) ? IV_MAX : interval_r);

  // captured item
  logic [ACT_W-1:0]    action_r;
  logic [NODE_W-1:0]   node_r;
  logic [IDX_W-1:0]    node_addr_r;
  logic [TTL_IN_W-1:0] ttl_r;
  logic                ovw_r;
  logic [TYPE_W-1:0]   type_r;
  logic [TYPE_W-1:0]   pick_r;
  logic [XT_W-1:0]     ext_ticks_r;
  logic [SECS_W-1:0]   ext_secs_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      action_r    <= in_action;
      node_r      <= in_node_index;
      node_addr_r <= IDX_W'(in_node_index);
      ttl_r       <= in_requested_ttl;
      ovw_r       <= in_overwrite;
      type_r      <= in_requested_type;
      pick_r      <= in_random_pick;
      ext_ticks_r <= in_extend_ticks;
      ext_secs_r  <= in_extend_seconds;
    end
  end

  // table state
  logic [MAX_NODES-1:0] active_r;
  logic [CNT_W-1:0]     total_r;
  logic [IDX_W-1:0]     scan_idx_r;

  logic               node_ok;
  logic               tgt_active;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [TYPE_W-1:0]  cur_kind;
  logic [TICKS_W-1:0] cur_ticks;

  assign node_ok    = {1'b0, node_r} < limit;
  assign tgt_active = node_ok && active_r[node_addr_r];
  assign cur_kind   = ram_rdata[ENTRY_W-1:TICKS_W];
  assign cur_ticks  = ram_rdata[TICKS_W-1:0];

  nftt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_NODES)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // divider for derived extension
  logic              div_busy;
  logic [SECS_W-1:0] div_quot;
  logic              div_rem_nz;

  nftt_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.start_div),
    .dividend(ext_secs_r),
    .divisor (iv),
    .busy    (div_busy),
    .quotient(div_quot),
    .rem_nz  (div_rem_nz)
  );

  // operand clamps
  logic [TYPE_W-1:0]  new_type;
  logic [TICKS_W-1:0] new_ttl;
  logic [RAW_W-1:0]   derived;
  logic [RAW_W-1:0]   raw_delta;
  logic [DELTA_W-1:0] delta;
  logic [SUM_W-1:0]   sum;
  logic [TICKS_W-1:0] ext_total;

  always_comb begin
    if (type_r == TYPE_AUTO || type_r == TYPE_AUTO_ALT) begin
      if (pick_r < TYPE_MIN) begin
        new_type = TYPE_MIN;
      end else if (pick_r > TYPE_MAX) begin
        new_type = TYPE_MAX;
      end else begin
        new_type = pick_r;
      end
    end else begin
      new_type = type_r;
    end
  end

  assign new_ttl   = (ttl_r == '0) ? TICKS_W'(1) :
                     ((ttl_r > TTL_MAX) ? TICKS_W'(TTL_MAX) : TICKS_W'(ttl_r));
  // ceil(seconds / interval) = floor + (remainder != 0)
  assign derived   = {1'b0, div_quot} + RAW_W'(div_rem_nz);
  assign raw_delta = (ext_ticks_r != '0) ? RAW_W'(ext_ticks_r) : derived;
  assign delta     = (raw_delta == '0) ? DELTA_W'(1) :
                     ((raw_delta > RAW_W'(DELTA_MAX)) ? DELTA_MAX : raw_delta[DELTA_W-1:0]);
  assign sum       = {1'b0, cur_ticks} + SUM_W'(delta);
  assign ext_total = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TICKS_W-1:0];

  // single-item result decode
  logic [RES_W-1:0]   ex_res;
  logic [TYPE_W-1:0]  ex_type;
  logic [TICKS_W-1:0] ex_rem;
  logic [DELTA_W-1:0] ex_delta;
  logic               ex_wr;
  logic [ENTRY_W-1:0] ex_wdata;
  logic               ex_set;
  logic               ex_clr;
  logic [CNT_W-1:0]   ex_total;

  always_comb begin
    ex_res   = RES_INVALID;
    ex_type  = '0;
    ex_rem   = '0;
    ex_delta = '0;
    ex_wr    = 1'b0;
    ex_wdata = {new_type, new_ttl};
    ex_set   = 1'b0;
    ex_clr   = 1'b0;
    if (node_ok) begin
      case (action_r)
        ACT_INJECT: begin
          if (tgt_active && !ovw_r) begin
            ex_res  = RES_SKIPPED;
            ex_type = cur_kind;
            ex_rem  = cur_ticks;
          end else begin
            ex_res  = RES_INJECTED;
            ex_type = new_type;
            ex_rem  = new_ttl;
            ex_wr   = 1'b1;
            ex_set  = 1'b1;
          end
        end
        ACT_REMOVE: begin
          if (tgt_active) begin
            ex_res  = RES_REMOVED;
            ex_type = cur_kind;
            ex_clr  = 1'b1;
          end
        end
        ACT_EXTEND: begin
          if (tgt_active) begin
            ex_res   = RES_EXTENDED;
            ex_type  = cur_kind;
            ex_rem   = ext_total;
            ex_delta = delta;
            ex_wr    = 1'b1;
            ex_wdata = {cur_kind, ext_total};
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    ex_total = total_r;
    if (ex_set && !tgt_active) begin
      ex_total = total_r + 1'b1;
    end else if (ex_clr && total_r != '0) begin
      ex_total = total_r - 1'b1;
    end
  end

  // tick decrement
  logic [TICKS_W-1:0] dec_ticks;
  logic               expire;
  logic [CNT_W-1:0]   upd_total;

  assign dec_ticks = (cur_ticks != '0) ? cur_ticks - 1'b1 : '0;
  assign expire    = dec_ticks == '0;
  assign upd_total = (total_r != '0) ? total_r - 1'b1 : '0;

  assign ram_re    = cmd.load_item | cmd.scan_rd;
  assign ram_raddr = cmd.load_item ? IDX_W'(in_node_index) : scan_idx_r;
  assign ram_we    = (cmd.exec && ex_wr) || (cmd.update && !expire);
  assign ram_waddr = cmd.exec ? node_addr_r : scan_idx_r;
  assign ram_wdata = cmd.exec ? ex_wdata : {cur_kind, dec_ticks};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      total_r  <= '0;
    end else if (cmd.exec) begin
      if (ex_set) begin
        active_r[node_addr_r] <= 1'b1;
      end
      if (ex_clr) begin
        active_r[node_addr_r] <= 1'b0;
      end
      total_r <= ex_total;
    end else if (cmd.update && expire) begin
      active_r[scan_idx_r] <= 1'b0;
      total_r              <= upd_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_init) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_next) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
  end

  // output register
  logic               load_out;
  logic               out_valid_r;
  logic [RES_W-1:0]   res_r;
  logic [NODE_W-1:0]  node_out_r;
  logic [TYPE_W-1:0]  type_out_r;
  logic [TICKS_W-1:0] rem_out_r;
  logic [DELTA_W-1:0] delta_out_r;
  logic [CNT_W-1:0]   total_out_r;
  logic               last_r;

  assign load_out = cmd.exec || (cmd.update && expire) || cmd.done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r       <= ex_res;
      node_out_r  <= node_r;
      type_out_r  <= ex_type;
      rem_out_r   <= ex_rem;
      delta_out_r <= ex_delta;
      total_out_r <= ex_total;
      last_r      <= 1'b1;
    end else if (cmd.update && expire) begin
      res_r       <= RES_EXPIRED;
      node_out_r  <= NODE_W'(scan_idx_r);
      type_out_r  <= cur_kind;
      rem_out_r   <= '0;
      delta_out_r <= '0;
      total_out_r <= upd_total;
      last_r      <= 1'b0;
    end else if (cmd.done) begin
      res_r       <= RES_TICK_DONE;
      node_out_r  <= '0;
      type_out_r  <= '0;
      rem_out_r   <= '0;
      delta_out_r <= '0;
      total_out_r <= total_r;
      last_r      <= 1'b1;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_res       = res_r;
  assign out_event_node      = node_out_r;
  assign out_event_type      = type_out_r;
  assign out_remaining_ticks = rem_out_r;
  assign out_applied_delta   = delta_out_r;
  assign out_live_count      = total_out_r;
  assign out_last            = last_r;

  assign stat.limit_zero = limit == '0;
  assign stat.need_div   = tgt_active && action_r == ACT_EXTEND && ext_ticks_r == '0;
  assign stat.div_busy   = div_busy;
  assign stat.scan_hit   = active_r[scan_idx_r];
  assign stat.scan_last  = scan_idx_r == LAST_IDX;
  assign stat.slot_free  = !out_valid_r || out_ready;

endmodule

[rtl/nftt_ctrl.sv]
// nftt_ctrl: sequencer for lookup, divide, execute and the tick scan.
// Depends on nftt_pkg.
module nftt_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [nftt_pkg::ACT_W-1:0] in_action,
  output logic                       in_ready,
  input  nftt_pkg::stat_t            stat,
  output nftt_pkg::cmd_t             cmd
);
  import nftt_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LOOKUP = 7'b0000010,
    ST_DIVIDE = 7'b0000100,
    ST_EXEC   = 7'b0001000,
    ST_SCAN   = 7'b0010000,
    ST_UPDATE = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (in_action == ACT_TICK) begin
            cmd.scan_init = 1'b1;
            state_nxt     = stat.limit_zero ? ST_DONE : ST_SCAN;
          end else begin
            state_nxt = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        if (stat.need_div) begin
          cmd.start_div = 1'b1;
          state_nxt     = ST_DIVIDE;
        end else begin
          state_nxt = ST_EXEC;
        end
      end
      ST_DIVIDE: begin
        if (!stat.div_busy) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.slot_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (stat.scan_hit) begin
          cmd.scan_rd = 1'b1;
          state_nxt   = ST_UPDATE;
        end else if (stat.scan_last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      ST_UPDATE: begin
        if (stat.slot_free) begin
          cmd.update = 1'b1;
          if (stat.scan_last) begin
            state_nxt = ST_DONE;
          end else begin
            cmd.scan_next = 1'b1;
            state_nxt     = ST_SCAN;
          end
        end
      end
      ST_DONE: begin
        if (stat.slot_free) begin
          cmd.done  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = state_r == ST_IDLE;

endmodule
